### rtl/core/audio_sample_resampler_core_assert.svh
// ----------------------------------------------------------------------------
// Resampler assertion macros
// Shared concurrent assertion forms for the resampler checker.
// ----------------------------------------------------------------------------
`ifndef AUDIO_SAMPLE_RESAMPLER_CORE_ASSERT_SVH
`define AUDIO_SAMPLE_RESAMPLER_CORE_ASSERT_SVH

// Plain clocked assertion, disabled while reset is asserted.
`define ASR_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("resampler assertion failed");

// A stalled word keeps its payload on the next cycle.
`define ASR_ASSERT_HOLD(lbl, clk, rst_n, vld, stl, sig) \
  `ASR_ASSERT(lbl, clk, rst_n, (vld && stl) |=> $stable(sig))

`endif

### rtl/core/asr_pkg.sv
// ----------------------------------------------------------------------------
// Resampler package
// Word types, register indexes and controller/datapath interface structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package asr_pkg;

  localparam int unsigned SampleW   = 16;
  localparam int unsigned StepW     = 20;
  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned CountW    = 7;

  localparam logic [CountW-1:0] MaxResults = 7'd64;
  localparam logic [16:0]       OnePos     = 17'h10000;
  localparam logic [StepW-1:0]  StepReset  = 20'd81920;

  localparam logic [CfgIndexW-1:0] RegMode = 2'd0;
  localparam logic [CfgIndexW-1:0] RegStep = 2'd1;

  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic                      end_of_file;
  } in_word_t;

  typedef struct packed {
    logic signed [SampleW-1:0] out_sample;
    logic                      last_of_run;
  } out_word_t;

  typedef struct packed {
    logic accept;     // latch the incoming word
    logic latch_d;    // register the interpolation weight
    logic mul;        // form the product and advance the position
    logic fin;        // round the result into the pending slot
    logic push;       // move the pending result to the output register
    logic push_last;  // mark the pushed result as the last of its run
    logic finish;     // update index and history at the end of a word
  } asr_cmd_t;

  typedef struct packed {
    logic hit;        // current position falls in this sample window
    logic cap;        // result limit reached for this word
    logic pending;    // a finished result waits to be pushed
    logic out_free;   // output register can take a word this cycle
  } asr_status_t;

endpackage

`default_nettype wire

### rtl/core/audio_sample_resampler_core.sv
// ----------------------------------------------------------------------------
// Audio sample resampler core
// A word is taken in the idle state; each result then passes through test,
// multiply and round, and moves to the output register at the next test.
// The block takes no new word until a test ends the word's run, as the
// single shared multiplier serves the controller's test/multiply/round loop.
// Reset clears position, index, history and registers (mode 0, step 81920).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

// The block keeps a fixed-point read position in Q(INDEX_BITS).16 form and
// advances it by the programmed step after every result. Each incoming word
// opens a window one sample wide; every position that falls in that window
// produces one result while the word is held.
//
// In nearest mode the result is the incoming sample itself. In linear mode
// the target lies one step ahead of the accumulator and the result blends
// the previous and the current sample by the fractional distance, rounded
// toward zero. Nearest mode reuses the same path with a full weight, which
// reduces the blend to the current sample.
//
// The finished result waits in a pending slot until the next window test has
// decided whether it is the last of its run, and then moves to the output
// register. At most 64 results are produced for one word. At the end of a
// clip the position, index and history return to zero.
//
// Configuration writes are always accepted; they are meant to happen only
// while the block is idle.
module audio_sample_resampler_core #(
  parameter int unsigned INDEX_BITS = 32
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            in_valid_i,
  output logic                           in_stall_o,
  input  asr_pkg::in_word_t              in_data_i,
  output logic                           out_valid_o,
  input  wire                            out_stall_i,
  output asr_pkg::out_word_t             out_data_o,
  input  wire                            cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire  [asr_pkg::CfgIndexW-1:0]  cfg_index_i,
  input  wire  [asr_pkg::StepW-1:0]      cfg_data_i
);
  import asr_pkg::*;

  asr_cmd_t    cmd;
  asr_status_t status;

  // Register writes never wait.
  assign cfg_ready_o = 1'b1;

  asr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  asr_datapath #(
    .INDEX_BITS (INDEX_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

### rtl/core/asr_ctrl.sv
// ----------------------------------------------------------------------------
// Resampler controller
// Sequences test, multiply and rounding steps for each accepted word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module asr_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  asr_pkg::asr_status_t status_i,
  output asr_pkg::asr_cmd_t    cmd_o
);
  import asr_pkg::*;

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StTest = 4'b0010,
    StMul  = 4'b0100,
    StFin  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   can_push;

  assign can_push   = !status_i.pending || status_i.out_free;
  assign in_stall_o = (state_q != StIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = StTest;
        end
      end
      StTest: begin
        if (can_push) begin
          cmd_o.push = status_i.pending;
          if (status_i.hit && !status_i.cap) begin
            cmd_o.latch_d = 1'b1;
            state_d       = StMul;
          end else begin
            cmd_o.push_last = 1'b1;
            cmd_o.finish    = 1'b1;
            state_d         = StIdle;
          end
        end
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        state_d   = StFin;
      end
      StFin: begin
        cmd_o.fin = 1'b1;
        state_d   = StTest;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

### rtl/core/asr_datapath.sv
// ----------------------------------------------------------------------------
// Resampler datapath
// Position accumulator, window test, interpolation multiplier and output
// register, driven by the controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module asr_datapath #(
  parameter int unsigned INDEX_BITS = 32
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  asr_pkg::in_word_t                   in_data_i,
  input  wire                                 cfg_valid_i,
  input  wire  [asr_pkg::CfgIndexW-1:0]       cfg_index_i,
  input  wire  [asr_pkg::StepW-1:0]           cfg_data_i,
  input  asr_pkg::asr_cmd_t                   cmd_i,
  output asr_pkg::asr_status_t                status_o,
  input  wire                                 out_stall_i,
  output logic                                out_valid_o,
  output asr_pkg::out_word_t                  out_data_o
);
  import asr_pkg::*;

  localparam int unsigned PosW = INDEX_BITS + 16;

  logic                    mode_q;
  logic [StepW-1:0]        step_q;
  logic [PosW-1:0]         pos_q;
  logic [INDEX_BITS-1:0]   idx_q;
  logic signed [15:0]      prev_q;
  logic signed [15:0]      cur_q;
  logic                    eof_q;
  logic [16:0]             d_q;
  logic signed [34:0]      prod_q;
  logic signed [15:0]      val_q;
  logic                    pending_q;
  logic [CountW-1:0]       count_q;
  logic                    out_valid_q;
  out_word_t               out_data_q;

  logic [PosW-1:0]         base;
  logic [PosW-1:0]         pos_step;
  logic [PosW-1:0]         d_lin;
  logic [PosW-1:0]         d_near;
  logic                    hit;
  logic signed [16:0]      diff;
  logic signed [17:0]      d_s;
  logic signed [34:0]      prod_d;
  logic signed [35:0]      mix;
  logic signed [15:0]      val_d;

  assign base     = {idx_q, 16'b0};
  assign pos_step = pos_q + PosW'(step_q);
  assign d_lin    = pos_step + PosW'(OnePos) - base;
  assign d_near   = pos_q - base;

  // Linear targets lie one step ahead and need (n-1) < target <= n.
  always_comb begin
    if (mode_q) begin
      hit = (d_lin != '0) && (d_lin <= PosW'(OnePos));
    end else begin
      hit = (d_near < PosW'(OnePos));
    end
  end

  // prev*(1-d) + cur*d is written as prev + (cur-prev)*d to use one multiplier.
  assign diff   = {cur_q[15], cur_q} - {prev_q[15], prev_q};
  assign d_s    = {1'b0, d_q};
  assign prod_d = diff * d_s;
  assign mix    = {prod_q[34], prod_q} + {{4{prev_q[15]}}, prev_q, 16'b0};
  assign val_d  = mix[31:16] + 16'(mix[35] && (mix[15:0] != 16'd0));

  assign status_o.hit      = hit;
  assign status_o.cap      = (count_q == MaxResults);
  assign status_o.pending  = pending_q;
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      step_q <= StepReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegMode: mode_q <= cfg_data_i[0];
        RegStep: step_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      idx_q       <= '0;
      prev_q      <= '0;
      pending_q   <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        count_q <= '0;
      end
      if (cmd_i.mul) begin
        pos_q   <= pos_step;
        count_q <= count_q + CountW'(1);
      end
      if (cmd_i.fin) begin
        pending_q <= 1'b1;
      end else if (cmd_i.push) begin
        pending_q <= 1'b0;
      end
      if (cmd_i.push) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.finish) begin
        if (eof_q) begin
          pos_q  <= '0;
          idx_q  <= '0;
          prev_q <= '0;
        end else begin
          idx_q  <= idx_q + INDEX_BITS'(1);
          prev_q <= cur_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cur_q <= in_data_i.sample;
      eof_q <= in_data_i.end_of_file;
    end
    if (cmd_i.latch_d) begin
      d_q <= mode_q ? d_lin[16:0] : OnePos;
    end
    if (cmd_i.mul) begin
      prod_q <= prod_d;
    end
    if (cmd_i.fin) begin
      val_q <= val_d;
    end
    if (cmd_i.push) begin
      out_data_q.out_sample  <= val_q;
      out_data_q.last_of_run <= cmd_i.push_last;
    end
  end

endmodule

`default_nettype wire

### rtl/core/asr_checker.sv
// ----------------------------------------------------------------------------
// Resampler port checker
// Watches the top-level ports for handshake and sequencing slips.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "audio_sample_resampler_core_assert.svh"

module asr_checker (
  input wire                clk_i,
  input wire                rst_ni,
  input wire                in_valid_i,
  input wire                in_stall_o,
  input wire                out_valid_o,
  input wire                out_stall_i,
  input asr_pkg::out_word_t out_data_o
);
  import asr_pkg::*;

  // A stalled result word stays offered.
  `ASR_ASSERT(a_out_valid_hold, clk_i, rst_ni, (out_valid_o && out_stall_i) |=> out_valid_o)

  // A stalled result word keeps its payload.
  `ASR_ASSERT_HOLD(a_out_data_hold, clk_i, rst_ni, out_valid_o, out_stall_i, out_data_o)

  // Once a word is taken the block is busy on the next cycle.
  `ASR_ASSERT(a_busy_after_accept, clk_i, rst_ni, (in_valid_i && !in_stall_o) |=> in_stall_o)

  // New results only appear while a word is being worked on.
  `ASR_ASSERT(a_result_needs_work, clk_i, rst_ni, $rose(out_valid_o) |-> $past(in_stall_o))

endmodule

bind audio_sample_resampler_core asr_checker u_asr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

### test/audio_sample_resampler_core_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Resampler result checker
// Watches the configuration, input and output channels of the resampler core,
// predicts every output word from its own copy of the registers and state,
// and compares each accepted output word field by field in arrival order.
// ----------------------------------------------------------------------------

module audio_sample_resampler_core_check
  import asr_pkg::*;
#(
  parameter int unsigned INDEX_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  in_word_t             in_data_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  out_word_t            out_data_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [StepW-1:0]     cfg_data_i,
  output int                   pending_o,
  output int                   error_count_o
);

  localparam int unsigned       PosW       = INDEX_BITS + 16;
  localparam longint unsigned   Unity      = OnePos;
  localparam int                MaxOut     = int'(MaxResults);
  localparam int                PrintLimit = 100;

  // Register copies and resampling state.
  logic                      lin_mode;
  logic [StepW-1:0]          step_reg;
  logic [PosW-1:0]           position;
  logic [INDEX_BITS-1:0]     word_index;
  logic signed [SampleW-1:0] last_sample;

  out_word_t resampled_q[$];
  out_word_t want;
  int        mismatch_count = 0;
  int        result_count = 0;

  task automatic report_mismatch(input string msg);
    // Keep the log short when the design is badly broken.
    if (mismatch_count < PrintLimit) $display("%0t: mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // Works out every output word that one input word causes.
  task automatic resample_word(input in_word_t w);
    logic [PosW-1:0] window_base;
    logic [PosW-1:0] target;
    logic [PosW-1:0] offset;
    longint          blend;
    longint          quot;
    out_word_t       res;
    int              produced;
    produced    = 0;
    window_base = {word_index, 16'h0000};
    while (produced < MaxOut) begin
      if (!lin_mode) begin
        offset = position - window_base;
        if (offset >= Unity) break;
        res.out_sample = w.sample;
      end else begin
        target = position + step_reg;
        offset = target + Unity - window_base;
        if (offset == 0 || offset > Unity) break;
        blend = longint'(last_sample) * longint'(Unity - offset)
              + longint'(w.sample) * longint'(offset);
        quot  = blend / 65536;
        res.out_sample = quot[SampleW-1:0];
      end
      res.last_of_run = 1'b0;
      resampled_q.insert(resampled_q.size(), res);
      produced++;
      position += step_reg;
    end
    if (produced > 0) resampled_q[resampled_q.size()-1].last_of_run = 1'b1;
    if (w.end_of_file) begin
      position    = '0;
      word_index  = '0;
      last_sample = '0;
    end else begin
      word_index  = word_index + 1'b1;
      last_sample = w.sample;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      resampled_q.delete();
      lin_mode      = 1'b0;
      step_reg      = StepReset;
      position      = '0;
      word_index    = '0;
      last_sample   = '0;
      pending_o     <= 0;
      error_count_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == RegMode) lin_mode = cfg_data_i[0];
        else if (cfg_index_i == RegStep) step_reg = cfg_data_i;
      end
      if (in_valid_i && !in_stall_i) resample_word(in_data_i);
      if (out_valid_i && !out_stall_i) begin
        if (resampled_q.size() == 0) begin
          report_mismatch($sformatf("unexpected word %0d: sample %0d last %0b", result_count,
                                    out_data_i.out_sample, out_data_i.last_of_run));
        end else begin
          want = resampled_q.pop_front();
          if (out_data_i.out_sample !== want.out_sample)
            report_mismatch($sformatf("word %0d out_sample %0d, expected %0d", result_count,
                                      out_data_i.out_sample, want.out_sample));
          if (out_data_i.last_of_run !== want.last_of_run)
            report_mismatch($sformatf("word %0d last_of_run %0b, expected %0b", result_count,
                                      out_data_i.last_of_run, want.last_of_run));
        end
        result_count++;
      end
      pending_o     <= resampled_q.size();
      error_count_o <= mismatch_count;
    end
  end

endmodule

### test/audio_sample_resampler_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Resampler core testbench
// Drives sample words and register writes into the resampler core, with
// random gaps on the input side and random stalls on the output side, while
// a separate checker predicts and compares every output word.
// ----------------------------------------------------------------------------

module audio_sample_resampler_core_test;
  import asr_pkg::*;

  localparam int HalfPeriod   = 1;
  localparam int ResetCycles  = 6;
  // A word giving the full 64 results keeps the core busy the longest, and
  // this many quiet cycles are enough for it to finish any word.
  localparam int WordCycles   = 200;
  // Longest stretch without any accepted word that a correct run can show is
  // about WordCycles plus one long stall; the limit is well above that.
  localparam int QuietLimit   = 4000;
  localparam int Phases       = 8;
  localparam int PhaseWords   = 35;

  localparam logic [StepW-1:0]     StepLow    = 20'd1024;
  localparam logic [StepW-1:0]     StepHigh   = 20'hFFFFF;
  // Indexes that name no register; writes to them must change nothing.
  localparam logic [CfgIndexW-1:0] RegSpareLo = 2'd2;
  localparam logic [CfgIndexW-1:0] RegSpareHi = 2'd3;
  localparam logic                 ModeNear   = 1'b0;
  localparam logic                 ModeLin    = 1'b1;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_word_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_word_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CfgIndexW-1:0] cfg_index = '0;
  logic [StepW-1:0]     cfg_data = '0;

  int          pending;
  int          errors;
  int unsigned quiet_cycles = 0;
  bit          burst_mode = 1'b0;

  always #HalfPeriod clk_i = ~clk_i;

  audio_sample_resampler_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  audio_sample_resampler_core_check result_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .in_data_i     (in_data),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_data_i    (out_data),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .pending_o     (pending),
    .error_count_o (errors)
  );

  // Idle lengths come from three ranges: most often the shortest, now and then
  // the middle one, and rarely the longest, a long pause.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    else if (r < 92) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  // Full-scale values and zero turn up often; the rest is uniform noise.
  function automatic logic signed [SampleW-1:0] pick_sample();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r == 0) return 16'sh7FFF;
    else if (r == 1) return 16'sh8000;
    else if (r == 2) return '0;
    else return SampleW'($urandom);
  endfunction

  // Steps near unity are picked most often and most words give no more than two results;
  // the range limits and a spread over the whole range appear as well.
  function automatic logic [StepW-1:0] pick_step();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return StepLow;
    else if (r == 1) return StepHigh;
    else if (r < 6) return StepW'($urandom_range(40000, 140000));
    else if (r < 9) return StepW'($urandom_range(140000, 400000));
    else return StepW'($urandom_range(StepLow, StepHigh));
  endfunction

  // Offers one sample word and returns at the edge where it is taken. A
  // random gap comes first for about half of the words, never in a burst
  // stretch; with no gap the valid simply stays high from the previous word.
  task automatic send_word(input logic signed [SampleW-1:0] s, input logic eof);
    int unsigned gap;
    in_word_t    w;
    gap = (burst_mode || $urandom_range(0, 1) == 0) ? 0 : idle_len();
    w.sample      = s;
    w.end_of_file = eof;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk_i); while (in_stall);
  endtask

  // Stops offering words, waits until the checker holds no expected word,
  // then lets the core finish a word that may still be testing positions.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (WordCycles) @(posedge clk_i);
  endtask

  // One register write; the caller lowers the valid after the last one so
  // that back-to-back writes keep it high.
  task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [StepW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
  endtask

  // Reprograms both registers while the core is idle. Only bit 0 of the mode
  // data counts, so the upper bits carry noise. Sometimes an unused index is
  // written too, which must leave the settings alone.
  task automatic configure(input logic mode_sel, input logic [StepW-1:0] step_sel);
    logic [StepW-1:0] filler;
    filler = StepW'($urandom);
    wait_drained();
    write_reg(RegMode, {filler[StepW-1:1], mode_sel});
    write_reg(RegStep, step_sel);
    if ($urandom_range(0, 2) == 0)
      write_reg($urandom_range(0, 1) ? RegSpareLo : RegSpareHi, StepW'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // Output stalls: short stalls separated by short free spells, with the
  // odd long free stretch and the odd long stall.
  initial begin
    @(posedge rst_ni);
    forever begin
      repeat (($urandom_range(0, 4) == 0) ? $urandom_range(60, 200) : idle_len())
        @(posedge clk_i);
      out_stall <= 1'b1;
      repeat (idle_len()) @(posedge clk_i);
      out_stall <= 1'b0;
    end
  end

  // Watchdog: ends the run if nothing moves on any channel for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("audio_sample_resampler_core_test: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned          clip_left;
    logic                 mode_sel;
    logic [StepW-1:0]     step_sel;
    logic                 eof;
    clip_left = 0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings, nearest mode at 1.25: full-scale swings and the
    // values around zero, ending the clip on the last word.
    send_word(16'sh7FFF, 1'b0);
    send_word(16'sh8000, 1'b0);
    send_word(16'sh0000, 1'b0);
    send_word(16'shFFFF, 1'b0);
    send_word(16'sh0001, 1'b1);

    // Linear mode at 1.5: halfway between opposite full-scale samples the
    // blend is minus one half, which must truncate towards zero. The first
    // word of the clip has no previous sample and gives nothing.
    configure(ModeLin, 20'd98304);
    send_word(16'sh8000, 1'b0);
    send_word(16'sh7FFF, 1'b0);
    send_word(16'sh8000, 1'b0);
    send_word(16'sh7FFF, 1'b0);
    send_word(16'sh0000, 1'b1);

    // Smallest legal step in nearest mode: exactly 64 results per word.
    configure(ModeNear, StepLow);
    send_word(16'sh1234, 1'b0);
    send_word(16'shEDCB, 1'b1);

    // A step below the legal range in linear mode: the result limit cuts the
    // window short, the position falls behind and nothing more comes out
    // until the end of the clip.
    configure(ModeLin, 20'd700);
    send_word(16'sh4000, 1'b0);
    send_word(16'shC000, 1'b0);
    send_word(16'sh7FFF, 1'b1);

    // Largest step: most words give no result at all. The clip is left
    // open and the mode and step change in the middle of it.
    configure(ModeNear, StepHigh);
    send_word(16'sh0101, 1'b0);
    send_word(16'sh7FFF, 1'b0);
    send_word(16'sh8000, 1'b0);
    send_word(16'sh5555, 1'b0);
    configure(ModeLin, 20'd40000);
    send_word(16'shAAAA, 1'b0);
    send_word(16'sh0F0F, 1'b0);
    send_word(16'shF0F0, 1'b1);

    // A zero step holds the position still, so the limit bounds the run.
    configure(ModeLin, 20'd0);
    send_word(16'sh7FFF, 1'b0);
    send_word(16'sh8000, 1'b1);

    // Random phases. Most words form clips closed by an end-of-file word;
    // a few stray end-of-file flags cut clips short, and a clip still open
    // at the end of a phase sees the settings change under it.
    for (int phase = 0; phase < Phases; phase++) begin
      mode_sel = (phase < 2) ? ModeLin : 1'($urandom);
      step_sel = (phase == 0) ? StepLow : (phase == 1) ? StepHigh : pick_step();
      configure(mode_sel, step_sel);
      burst_mode = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < PhaseWords; n++) begin
        // Once in the run the sender holds back until every result is out.
        if (phase == 3 && n == PhaseWords / 2) wait_drained();
        if (clip_left == 0) clip_left = $urandom_range(1, 30);
        eof = (clip_left == 1) || ($urandom_range(0, 19) == 0);
        clip_left = eof ? 0 : clip_left - 1;
        send_word(pick_sample(), eof);
      end
    end

    wait_drained();
    if (errors == 0 && pending == 0) begin
      $display("audio_sample_resampler_core_test: done, clean");
    end else begin
      $display("audio_sample_resampler_core_test: done, errors");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/asr_pkg.sv
rtl/core/asr_ctrl.sv
rtl/core/asr_datapath.sv
rtl/core/audio_sample_resampler_core.sv
rtl/core/asr_checker.sv
test/audio_sample_resampler_core_check.sv
test/audio_sample_resampler_core_test.sv
